// ===== sv/rtce_pkg.sv =====
// Shared types and helpers for the RTC BCD date to epoch seconds converter.
// Holds the decoded-field struct, calendar constants and the month start table.
// No dependencies.
package rtce_pkg;

    localparam int unsigned EPOCH_W  = 32;
    localparam int unsigned YDAY_W   = 9;
    localparam int unsigned DAYS_W   = 17;
    localparam int unsigned HMS_W    = 18;

    localparam logic [7:0]  YEAR_PIVOT     = 8'd70;
    localparam logic [7:0]  CENTURY_OFFSET = 8'd30;
    localparam logic [4:0]  MONTH_DEC      = 5'd12;
    localparam logic [4:0]  MONTH_FEB      = 5'd2;
    localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
    localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
    localparam logic [HMS_W-1:0] SECS_PER_HOUR = 18'd3600;
    localparam logic [HMS_W-1:0] SECS_PER_MIN  = 18'd60;

    // Decoded snapshot, produced by the first stage
    typedef struct packed {
        logic [6:0] sec;
        logic [6:0] min;
        logic [5:0] hour;
        logic [5:0] mday;
        logic [6:0] years;     // years since 1970
        logic [3:0] midx;      // month clamped to 0..12
        logic       past_feb;
    } rtce_fields_t;

    // Packed BCD byte to binary; digits above nine are not checked
    function automatic logic [7:0] bcd_byte_value(input logic [7:0] v);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'd0, v[7:4]};
        lo = {4'd0, v[3:0]};
        return {hi[4:0], 3'b000} + {hi[6:0], 1'b0} + lo;
    endfunction

    // Days before the first of each month, leap-year February
    function automatic logic [YDAY_W-1:0] month_start(input logic [3:0] midx);
        logic [YDAY_W-1:0] d;
        case (midx)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd60;
            4'd4:    d = 9'd91;
            4'd5:    d = 9'd121;
            4'd6:    d = 9'd152;
            4'd7:    d = 9'd182;
            4'd8:    d = 9'd213;
            4'd9:    d = 9'd244;
            4'd10:   d = 9'd274;
            4'd11:   d = 9'd305;
            4'd12:   d = 9'd335;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rtc_bcd_date_to_epoch_seconds.sv =====
// RTC BCD snapshot to seconds since 1970 and day of year.
// Throughput one request per cycle while the output is not stalled by m_tready.
// Four register stages: decode, day count, day-to-seconds multiply, final sum.
// Backpressure stalls only stages that hold data; a stalled result sits in the output register.
// Reset (rst_n low, asynchronous) clears all stage valid bits; payload registers are not reset.
module rtc_bcd_date_to_epoch_seconds
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [6:0] second_bcd, [13:7] minute_bcd, [19:14] hour_bcd, [25:20] day_bcd,
    // [30:26] month_bcd, [38:31] year_bcd, [39] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] epoch_seconds, [40:32] day_of_year, [47:41] zero
    output logic [47:0] m_tdata
);
    import rtce_pkg::*;

    // Stage enables: a stage loads when it is empty or its content moves on
    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: decoded fields
    rtce_fields_t fields_next;
    rtce_fields_t f1_reg;

    // Stage 2: day count, day of year, time-of-day fields carried along
    logic [DAYS_W-1:0] days_next, days2_reg;
    logic [YDAY_W-1:0] yday_next, yday2_reg;
    logic [6:0]        sec2_reg, min2_reg;
    logic [5:0]        hour2_reg;

    // Stage 3: whole-day seconds and seconds within the day
    logic [EPOCH_W-1:0] dsec_next, dsec3_reg;
    logic [HMS_W-1:0]   hms_next, hms3_reg;
    logic [YDAY_W-1:0]  yday3_reg;

    // Stage 4: output register
    logic [EPOCH_W-1:0] epoch_next, epoch4_reg;
    logic [YDAY_W-1:0]  yday4_reg;

    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    rtce_decode u_decode
    (
        .second_bcd (s_tdata[6:0]),
        .minute_bcd (s_tdata[13:7]),
        .hour_bcd   (s_tdata[19:14]),
        .day_bcd    (s_tdata[25:20]),
        .month_bcd  (s_tdata[30:26]),
        .year_bcd   (s_tdata[38:31]),
        .fields     (fields_next)
    );

    // Day count: full years, leap days before this year, month start,
    // day of month less one; drop the leap day after February in a
    // common year. Leap years are those with (years + 2) divisible by 4.
    logic [15:0]       year_days;
    logic [7:0]        leap_days;
    logic [YDAY_W-1:0] mstart;
    logic              corr;

    always_comb
    begin
        year_days = 16'(f1_reg.years) * DAYS_PER_YEAR;
        leap_days = (8'(f1_reg.years) + 8'd1) >> 2;
        mstart    = month_start(f1_reg.midx);
        corr      = f1_reg.past_feb && ((f1_reg.years[1:0] + 2'd2) != 2'd0);
        days_next = DAYS_W'(year_days) + DAYS_W'(leap_days) + DAYS_W'(mstart)
                  + DAYS_W'(f1_reg.mday) - DAYS_W'(corr) - DAYS_W'(1);
        yday_next = mstart + YDAY_W'(f1_reg.mday) - YDAY_W'(corr);
    end

    // Day count may be minus one (day zero in January 1970); sign-extend
    // so the product wraps the same way.
    always_comb
    begin
        dsec_next = {{(EPOCH_W-DAYS_W){days2_reg[DAYS_W-1]}}, days2_reg} * SECS_PER_DAY;
        hms_next  = HMS_W'(hour2_reg) * SECS_PER_HOUR + HMS_W'(min2_reg) * SECS_PER_MIN
                  + HMS_W'(sec2_reg);
    end

    assign epoch_next = dsec3_reg + EPOCH_W'(hms3_reg);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= s_tvalid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload: advance with the enables, hold when stalled
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            f1_reg <= fields_next;
        end
        if (en2)
        begin
            days2_reg <= days_next;
            yday2_reg <= yday_next;
            sec2_reg  <= f1_reg.sec;
            min2_reg  <= f1_reg.min;
            hour2_reg <= f1_reg.hour;
        end
        if (en3)
        begin
            dsec3_reg <= dsec_next;
            hms3_reg  <= hms_next;
            yday3_reg <= yday2_reg;
        end
        if (en4)
        begin
            epoch4_reg <= epoch_next;
            yday4_reg  <= yday3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'd0, yday4_reg, epoch4_reg};

`ifndef SYNTHESIS
    // A request taken at the input shows up in the first stage
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted request did not reach stage one");

    // Without traffic on either side the number of held items stays put
    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready) && !(m_tvalid && m_tready)
        |=> $countones({v1_reg, v2_reg, v3_reg, v4_reg})
            == $past($countones({v1_reg, v2_reg, v3_reg, v4_reg})))
        else $error("pipeline lost or invented an item");

    // A stalled multiply stage keeps its product
    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !en3 |=> v3_reg && $stable(dsec3_reg) && $stable(hms3_reg))
        else $error("stage three changed while stalled");
`endif

endmodule

// ===== sv/rtce_decode.sv =====
// First-stage logic: BCD decode of all six bytes, year folding and month clamp.
// Depends on rtce_pkg.
module rtce_decode
(
    input  logic [6:0]            second_bcd,
    input  logic [6:0]            minute_bcd,
    input  logic [5:0]            hour_bcd,
    input  logic [5:0]            day_bcd,
    input  logic [4:0]            month_bcd,
    input  logic [7:0]            year_bcd,
    output rtce_pkg::rtce_fields_t fields
);
    import rtce_pkg::*;

    logic [7:0] sec_bin;
    logic [7:0] min_bin;
    logic [7:0] hour_bin;
    logic [7:0] mday_bin;
    logic [7:0] mon_bin;
    logic [7:0] yr_bin;
    logic [7:0] years_full;

    always_comb
    begin
        sec_bin  = bcd_byte_value({1'b0, second_bcd});
        min_bin  = bcd_byte_value({1'b0, minute_bcd});
        hour_bin = bcd_byte_value({2'b00, hour_bcd});
        mday_bin = bcd_byte_value({2'b00, day_bcd});
        mon_bin  = bcd_byte_value({3'b000, month_bcd});
        yr_bin   = bcd_byte_value(year_bcd);

        // Fold two-digit year: 70..99 is the 1900s, 00..69 the 2000s
        if (yr_bin >= YEAR_PIVOT)
        begin
            years_full = yr_bin - YEAR_PIVOT;
        end
        else
        begin
            years_full = yr_bin + CENTURY_OFFSET;
        end

        fields.sec      = sec_bin[6:0];
        fields.min      = min_bin[6:0];
        fields.hour     = hour_bin[5:0];
        fields.mday     = mday_bin[5:0];
        fields.years    = years_full[6:0];
        fields.midx     = (mon_bin[4:0] > MONTH_DEC) ? MONTH_DEC[3:0] : mon_bin[3:0];
        fields.past_feb = mon_bin[4:0] > MONTH_FEB;
    end

endmodule

// ===== tb/rtc_bcd_date_to_epoch_seconds_tb.sv =====
// Self-checking testbench for rtc_bcd_date_to_epoch_seconds: drives BCD clock snapshots,
// predicts epoch seconds and day of year, and checks every result in order.
// Depends only on the block itself; no package types are needed at its ports.
`timescale 1ns / 1ps

module rtc_bcd_date_to_epoch_seconds_tb;

    localparam int unsigned RANDOM_BLOCKS = 14;
    localparam int unsigned BLOCK_ITEMS   = 119;
    localparam int unsigned LONG_HOLD     = 150;
    localparam int unsigned HOLD_ITEMS    = 60;
    localparam int unsigned TAIL_CYCLES   = 12;
    localparam int unsigned TIMEOUT_NS    = 5_000_000;

    // Expected-result store and calendar predictor
    class epoch_scoreboard;
        typedef struct packed {
            logic [31:0] seconds;
            logic [8:0]  yday;
        } stamp_t;

        stamp_t      pending_stamps[$];
        int unsigned mismatches;
        int unsigned matched;

        function new();
            mismatches = 0;
            matched    = 0;
        endfunction

        function int unsigned days_in_month(int unsigned m, bit leap);
            if (m == 2)
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        // digits above nine keep their weight
        function int unsigned bcd_value(logic [7:0] v);
            return {28'd0, v[7:4]} * 32'd10 + {28'd0, v[3:0]};
        endfunction

        function int unsigned pending();
            return pending_stamps.size();
        endfunction

        function stamp_t snapshot_to_epoch(logic [39:0] d);
            int unsigned sec;
            int unsigned min;
            int unsigned hour;
            int unsigned mday;
            int unsigned mon;
            int unsigned yr;
            int unsigned years;
            int unsigned midx;
            int unsigned start;
            int unsigned short_feb;
            int unsigned day_count;
            stamp_t      stamp;
            sec  = bcd_value({1'b0, d[6:0]});
            min  = bcd_value({1'b0, d[13:7]});
            hour = bcd_value({2'b0, d[19:14]});
            mday = bcd_value({2'b0, d[25:20]});
            mon  = bcd_value({3'b0, d[30:26]});
            yr   = bcd_value(d[38:31]);
            // two-digit years below 70 belong to the 2000s
            years = (yr >= 70) ? yr - 70 : yr + 30;
            // month zero acts as January, anything past twelve as December
            midx  = (mon > 12) ? 12 : mon;
            start = 0;
            for (int k = 1; k < midx; k++)
                start += days_in_month(k, 1'b1);
            // offsets assume a leap February; drop a day after it otherwise
            short_feb = (((years + 2) % 4) != 0 && mon > 2) ? 1 : 0;
            day_count = 365 * years + (years + 1) / 4 + start - short_feb + mday - 1;
            stamp.seconds = day_count * 86400 + hour * 3600 + min * 60 + sec;
            stamp.yday    = 9'(start + mday - short_feb);
            return stamp;
        endfunction

        function void note_request(logic [39:0] d);
            pending_stamps.push_back(snapshot_to_epoch(d));
        endfunction

        function void check_result(logic [47:0] r);
            stamp_t want;
            bit     bad;
            bad = 1'b0;
            if (pending_stamps.size() == 0)
            begin
                $error("result %h arrived with no request pending", r);
                mismatches++;
                return;
            end
            want = pending_stamps.pop_front();
            if (r[31:0] !== want.seconds)
            begin
                $error("epoch_seconds: expected %0d, actual %0d", want.seconds, r[31:0]);
                bad = 1'b1;
            end
            if (r[40:32] !== want.yday)
            begin
                $error("day_of_year: expected %0d, actual %0d", want.yday, r[40:32]);
                bad = 1'b1;
            end
            if (r[47:41] !== 7'd0)
            begin
                $error("pad bits: expected %0d, actual %0d", 7'd0, r[47:41]);
                bad = 1'b1;
            end
            if (bad)
                mismatches++;
            else
                matched++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = 40'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    epoch_scoreboard sb;
    int unsigned     sent_count;
    int unsigned     directed_count;
    bit              tx_idle_on;
    bit              rx_idle_on;
    bit              long_hold_req;

    rtc_bcd_date_to_epoch_seconds uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Pack raw BCD bytes into the request word, second in the low bits
    function automatic logic [39:0] pack_snapshot(logic [7:0] sec, logic [7:0] min,
                                                  logic [7:0] hour, logic [7:0] mday,
                                                  logic [7:0] mon, logic [7:0] yr);
        return {1'b0, yr, mon[4:0], mday[5:0], hour[5:0], min[6:0], sec[6:0]};
    endfunction

    function automatic logic [7:0] to_bcd(int unsigned n);
        logic [3:0] tens;
        logic [3:0] ones;
        tens = 4'(n / 10);
        ones = 4'(n % 10);
        return {tens, ones};
    endfunction

    // Mostly real calendar dates; some with one field scrambled; some pure noise
    function automatic logic [39:0] random_snapshot();
        int unsigned pick;
        int unsigned yr;
        int unsigned mon;
        logic [39:0] d;
        pick = $urandom_range(0, 99);
        yr   = $urandom_range(0, 99);
        mon  = $urandom_range(1, 12);
        d = pack_snapshot(to_bcd($urandom_range(0, 59)), to_bcd($urandom_range(0, 59)),
                          to_bcd($urandom_range(0, 23)),
                          to_bcd($urandom_range(1, sb.days_in_month(mon, (yr % 4) == 0))),
                          to_bcd(mon), to_bcd(yr));
        if (pick >= 85)
        begin
            d = {1'b0, 7'($urandom_range(0, 127)), 32'($urandom)};
        end
        else if (pick >= 70)
        begin
            case ($urandom_range(0, 5))
                0:       d[6:0]   = 7'($urandom_range(0, 127));
                1:       d[13:7]  = 7'($urandom_range(0, 127));
                2:       d[19:14] = 6'($urandom_range(0, 63));
                3:       d[25:20] = 6'($urandom_range(0, 63));
                4:       d[30:26] = 5'($urandom_range(0, 31));
                default: d[38:31] = 8'($urandom_range(0, 255));
            endcase
        end
        return d;
    endfunction

    // Offer one request, with an optional idle burst ahead of it; hold until accepted
    task automatic send_snapshot(input logic [39:0] d);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= {1'b0, 7'($urandom_range(0, 127)), 32'($urandom)};
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
    endtask

    // Drop valid and hold off until every expected result is back
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 14);
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_request(s_tdata);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial
    begin
        int unsigned mode;
        bit          quiet;
        sb            = new();
        sent_count    = 0;
        tx_idle_on    = 1'b0;
        rx_idle_on    = 1'b1;
        long_hold_req = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, century pivot, leap handling, wraps, bad BCD digits
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_snapshot(pack_snapshot(8'h7F, 8'h7F, 8'h3F, 8'h3F, 8'h1F, 8'hFF));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h70));
        send_snapshot(pack_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h69));
        send_snapshot(pack_snapshot(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h00));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
        send_snapshot(pack_snapshot(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h01));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01));
        send_snapshot(pack_snapshot(8'h30, 8'h30, 8'h12, 8'h31, 8'h12, 8'h72));
        send_snapshot(pack_snapshot(8'h15, 8'h45, 8'h06, 8'h15, 8'h00, 8'h85));
        send_snapshot(pack_snapshot(8'h01, 8'h02, 8'h03, 8'h04, 8'h13, 8'h50));
        send_snapshot(pack_snapshot(8'h01, 8'h02, 8'h03, 8'h04, 8'h1F, 8'h71));
        send_snapshot(pack_snapshot(8'h08, 8'h14, 8'h03, 8'h19, 8'h01, 8'h38));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9F));
        send_snapshot(pack_snapshot(8'h7A, 8'h5F, 8'h3F, 8'h3F, 8'h0C, 8'h44));
        send_snapshot(pack_snapshot(8'h0F, 8'h6B, 8'h2E, 8'h0A, 8'h0A, 8'h1A));
        send_snapshot(pack_snapshot(8'h00, 8'h00, 8'h00, 8'h3F, 8'h12, 8'h69));
        directed_count = sent_count;

        // Pause the sender until the pipeline is empty
        wait_drained();

        // Long receiver hold-off while requests keep coming, to back the pipe up
        long_hold_req = 1'b1;
        repeat (HOLD_ITEMS)
            send_snapshot(random_snapshot());

        // Random blocks with a fresh idling mix each; the final stretch runs flat out
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            quiet      = (blk >= RANDOM_BLOCKS - 2);
            mode       = $urandom_range(0, 3);
            tx_idle_on = !quiet && (mode != 0 && mode != 2);
            rx_idle_on = !quiet && (mode >= 2);
            if (blk == RANDOM_BLOCKS / 2)
                wait_drained();
            repeat (BLOCK_ITEMS)
                send_snapshot(random_snapshot());
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d snapshots (%0d directed: pivot years, leap days, wraps, bad digits)",
                 sent_count, directed_count);
        $display("Checked %0d results under random stalls and one long output hold-off",
                 sb.matched + sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog against a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
